// ----- rtl/lssc_pkg.sv -----
package lssc_pkg;

    localparam int POS_W      = 18;
    localparam int PARK_W     = 17;
    localparam int DIR_W      = 2;
    localparam int PHASE_W    = 3;
    localparam int COIL_W     = 4;
    localparam int STAMP_W    = 32;
    localparam int INTERVAL_W = 23;
    localparam int LEVEL_W    = 16;
    localparam int INDEX_W    = 16;
    localparam int TICKS_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // travel geometry in steps
    localparam int END_MARGIN     = 100;
    localparam int REBOUND_OFFSET = 1000;

    // 0.6 in unsigned Q2.14
    localparam logic [INDEX_W-1:0] FORWARD_INDEX_LIMIT = 16'd9830;

    localparam logic signed [DIR_W-1:0] DIR_BACK    = -2'sd1;
    localparam logic signed [DIR_W-1:0] DIR_WANDER  = 2'sd0;
    localparam logic signed [DIR_W-1:0] DIR_FORWARD = 2'sd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRAVEL_LENGTH     = 3'd0,
        CFG_STEP_INTERVAL_US  = 3'd1,
        CFG_DARK_LEVEL        = 3'd2,
        CFG_BRIGHT_LEVEL      = 3'd3,
        CFG_INDEX_WINDOW_LOW  = 3'd4,
        CFG_INDEX_WINDOW_HIGH = 3'd5,
        CFG_DARK_PERSIST      = 3'd6,
        CFG_INDEX_PERSIST     = 3'd7
    } t_cfg_idx;

    localparam logic [15:0]           RST_TRAVEL_LENGTH     = 16'd30000;
    localparam logic [INTERVAL_W-1:0] RST_STEP_INTERVAL_US  = 23'd1000;
    localparam logic [LEVEL_W-1:0]    RST_DARK_LEVEL        = 16'd500;
    localparam logic [LEVEL_W-1:0]    RST_BRIGHT_LEVEL      = 16'd1000;
    localparam logic [INDEX_W-1:0]    RST_INDEX_WINDOW_LOW  = 16'd8192;
    localparam logic [INDEX_W-1:0]    RST_INDEX_WINDOW_HIGH = 16'd16220;
    localparam logic [TICKS_W-1:0]    RST_DARK_PERSIST      = 8'd5;
    localparam logic [TICKS_W-1:0]    RST_INDEX_PERSIST     = 8'd3;

    // half-step coil drive, bit0 is coil one
    function automatic logic [COIL_W-1:0] coil_lookup(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] coil;
        case (phase)
            3'd0:    coil = 4'h1;
            3'd1:    coil = 4'h3;
            3'd2:    coil = 4'h2;
            3'd3:    coil = 4'h6;
            3'd4:    coil = 4'h4;
            3'd5:    coil = 4'hC;
            3'd6:    coil = 4'h8;
            3'd7:    coil = 4'h9;
            default: coil = 4'h0;
        endcase
        return coil;
    endfunction

endpackage

// ----- rtl/lssc_if.sv -----
interface lssc_in_if;
    logic                            valid;
    logic                            ready;
    logic                            action;
    logic [lssc_pkg::STAMP_W-1:0]    now_us;
    logic [lssc_pkg::LEVEL_W-1:0]    light_level;
    logic [lssc_pkg::INDEX_W-1:0]    plant_index;
    logic                            step_back_pick;
    logic                            wander_pick;

    modport source (output valid, action, now_us, light_level, plant_index,
                    step_back_pick, wander_pick, input ready);
    modport sink   (input valid, action, now_us, light_level, plant_index,
                    step_back_pick, wander_pick, output ready);
endinterface

interface lssc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [lssc_pkg::COIL_W-1:0]          coil_pattern;
    logic signed [lssc_pkg::POS_W-1:0]    position;
    logic signed [lssc_pkg::DIR_W-1:0]    heading;
    logic                                 running;
    logic                                 stepped;

    modport source (output valid, coil_pattern, position, heading, running, stepped,
                    input ready);
    modport sink   (input valid, coil_pattern, position, heading, running, stepped,
                    output ready);
endinterface

interface lssc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lssc_pkg::CFG_IDX_W-1:0]    index;
    logic [lssc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/light_seeking_stepper_controller.sv -----
// channel   dir   transaction carries
// i_in      in    action, now_us, light_level, plant_index, step_back_pick, wander_pick
// o_out     out   coil_pattern, position, heading, running, stepped
// i_cfg     in    index, data (register write, always ready)
//
// one transaction in gives one transaction out; an item is held in the input
// register and is then resolved by combinational logic into the output register
// sustained rate is one item per cycle while o_out accepts, set by the input-to-result register pass
// i_rst_n is synchronous, active low, and restores the default register values
// when o_out stalls, the input register holds and i_in.ready drops after one more item
module light_seeking_stepper_controller (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lssc_in_if.sink    i_in,
    lssc_out_if.source o_out,
    lssc_cfg_if.sink   i_cfg
);

    localparam int POS_W = lssc_pkg::POS_W;

    localparam logic signed [POS_W-1:0] END_MARGIN_S = POS_W'(lssc_pkg::END_MARGIN);
    localparam logic signed [POS_W-1:0] REBOUND_S    = POS_W'(lssc_pkg::REBOUND_OFFSET);

    // configuration registers
    logic [15:0]                          r_travel_length;
    logic [lssc_pkg::INTERVAL_W-1:0]      r_step_interval_us;
    logic [lssc_pkg::LEVEL_W-1:0]         r_dark_level;
    logic [lssc_pkg::LEVEL_W-1:0]         r_bright_level;
    logic [lssc_pkg::INDEX_W-1:0]         r_index_window_low;
    logic [lssc_pkg::INDEX_W-1:0]         r_index_window_high;
    logic [lssc_pkg::TICKS_W-1:0]         r_dark_persist;
    logic [lssc_pkg::TICKS_W-1:0]         r_index_persist;

    // controller state
    logic signed [POS_W-1:0]              r_pos,   n_pos;
    logic signed [lssc_pkg::DIR_W-1:0]    r_dir,   n_dir;
    logic [lssc_pkg::PHASE_W-1:0]         r_phase, n_phase;
    logic                                 r_run,   n_run;
    logic [lssc_pkg::STAMP_W-1:0]         r_last,  n_last;
    logic signed [lssc_pkg::PARK_W-1:0]   r_park,  n_park;
    logic [lssc_pkg::TICKS_W-1:0]         r_dark_ticks, n_dark_ticks;
    logic [lssc_pkg::TICKS_W-1:0]         r_win_ticks,  n_win_ticks;
    logic                                 r_started, n_started;
    logic                                 n_stepped;

    // input register
    logic                                 r_in_valid;
    logic                                 r_action;
    logic [lssc_pkg::STAMP_W-1:0]         r_now;
    logic [lssc_pkg::LEVEL_W-1:0]         r_light;
    logic [lssc_pkg::INDEX_W-1:0]         r_idx;
    logic                                 r_back_pick;
    logic                                 r_wander_pick;

    // output register
    logic                                 r_out_valid;
    logic [lssc_pkg::COIL_W-1:0]          r_coil;
    logic signed [POS_W-1:0]              r_out_pos;
    logic signed [lssc_pkg::DIR_W-1:0]    r_out_dir;
    logic                                 r_out_run;
    logic                                 r_out_stepped;

    logic                                 advance;
    logic                                 in_ready;
    logic signed [POS_W-1:0]              travel_s;
    logic signed [POS_W-1:0]              hi_limit;
    logic signed [POS_W-1:0]              rebound_pos;
    logic [lssc_pkg::STAMP_W-1:0]         elapsed;
    logic signed [lssc_pkg::DIR_W-1:0]    step_dir;
    logic signed [POS_W-1:0]              stepped_pos;
    logic                                 dark_hit;

    assign advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_in_valid || advance;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    assign travel_s    = $signed({2'b00, r_travel_length});
    assign hi_limit    = travel_s - END_MARGIN_S;
    assign rebound_pos = travel_s - REBOUND_S;

    always_comb begin
        n_pos        = r_pos;
        n_dir        = r_dir;
        n_phase      = r_phase;
        n_run        = r_run;
        n_last       = r_last;
        n_park       = r_park;
        n_dark_ticks = r_dark_ticks;
        n_win_ticks  = r_win_ticks;
        n_started    = r_started;
        n_stepped    = 1'b0;
        elapsed      = r_now - r_last;
        step_dir     = (r_dir == lssc_pkg::DIR_WANDER)
                       ? (r_back_pick ? lssc_pkg::DIR_BACK : lssc_pkg::DIR_FORWARD)
                       : r_dir;
        stepped_pos  = r_pos;
        dark_hit     = 1'b0;

        if (r_action) begin
            if (r_started) begin
                if (r_wander_pick) begin
                    n_dir = lssc_pkg::DIR_WANDER;
                end else if (r_idx <= lssc_pkg::FORWARD_INDEX_LIMIT) begin
                    n_dir = lssc_pkg::DIR_FORWARD;
                end
                n_pos = POS_W'(r_park);
            end else begin
                n_dir     = lssc_pkg::DIR_FORWARD;
                n_park    = lssc_pkg::PARK_W'(1);
                n_started = 1'b1;
                n_pos     = POS_W'(1);
            end
            n_last = r_now;
            n_run  = 1'b1;
        end else if (r_run) begin
            if (elapsed >= {{(lssc_pkg::STAMP_W-lssc_pkg::INTERVAL_W){1'b0}},
                            r_step_interval_us}) begin
                stepped_pos = r_pos + {{(POS_W-lssc_pkg::DIR_W){step_dir[1]}}, step_dir};
                n_phase     = r_phase + {step_dir[1], step_dir};
                n_last      = r_now;
                n_stepped   = 1'b1;
            end
            n_pos = stepped_pos;

            // checks run in priority order, a bounce or a reversal ends them
            if (stepped_pos <= END_MARGIN_S) begin
                n_pos = rebound_pos;
                n_dir = lssc_pkg::DIR_FORWARD;
            end else if (stepped_pos >= hi_limit) begin
                n_pos = REBOUND_S;
                n_dir = lssc_pkg::DIR_BACK;
            end else begin
                if (r_dir != lssc_pkg::DIR_BACK && r_light < r_dark_level) begin
                    if (r_dark_ticks >= r_dark_persist) begin
                        dark_hit = 1'b1;
                    end else begin
                        n_dark_ticks = r_dark_ticks + 1'b1;
                    end
                end
                if (dark_hit) begin
                    n_dir       = lssc_pkg::DIR_BACK;
                    n_pos       = REBOUND_S;
                    n_win_ticks = '0;
                end else begin
                    if (r_light > r_bright_level) begin
                        n_dark_ticks = '0;
                    end
                    if (r_idx > r_index_window_low && r_idx < r_index_window_high) begin
                        if (r_win_ticks >= r_index_persist) begin
                            n_park      = lssc_pkg::PARK_W'(rebound_pos);
                            n_dir       = lssc_pkg::DIR_WANDER;
                            n_win_ticks = '0;
                            n_run       = 1'b0;
                        end else begin
                            n_win_ticks = r_win_ticks + 1'b1;
                        end
                    end else begin
                        n_win_ticks = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_travel_length     <= lssc_pkg::RST_TRAVEL_LENGTH;
            r_step_interval_us  <= lssc_pkg::RST_STEP_INTERVAL_US;
            r_dark_level        <= lssc_pkg::RST_DARK_LEVEL;
            r_bright_level      <= lssc_pkg::RST_BRIGHT_LEVEL;
            r_index_window_low  <= lssc_pkg::RST_INDEX_WINDOW_LOW;
            r_index_window_high <= lssc_pkg::RST_INDEX_WINDOW_HIGH;
            r_dark_persist      <= lssc_pkg::RST_DARK_PERSIST;
            r_index_persist     <= lssc_pkg::RST_INDEX_PERSIST;
        end else if (i_cfg.valid) begin
            case (lssc_pkg::t_cfg_idx'(i_cfg.index))
                lssc_pkg::CFG_TRAVEL_LENGTH:     r_travel_length     <= i_cfg.data[15:0];
                lssc_pkg::CFG_STEP_INTERVAL_US:  r_step_interval_us  <= i_cfg.data;
                lssc_pkg::CFG_DARK_LEVEL:        r_dark_level        <= i_cfg.data[15:0];
                lssc_pkg::CFG_BRIGHT_LEVEL:      r_bright_level      <= i_cfg.data[15:0];
                lssc_pkg::CFG_INDEX_WINDOW_LOW:  r_index_window_low  <= i_cfg.data[15:0];
                lssc_pkg::CFG_INDEX_WINDOW_HIGH: r_index_window_high <= i_cfg.data[15:0];
                lssc_pkg::CFG_DARK_PERSIST:      r_dark_persist      <= i_cfg.data[7:0];
                lssc_pkg::CFG_INDEX_PERSIST:     r_index_persist     <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_dir        <= lssc_pkg::DIR_FORWARD;
            r_phase      <= '0;
            r_run        <= 1'b0;
            r_last       <= '0;
            r_park       <= lssc_pkg::PARK_W'(1);
            r_dark_ticks <= '0;
            r_win_ticks  <= '0;
            r_started    <= 1'b0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (advance) begin
                r_pos        <= n_pos;
                r_dir        <= n_dir;
                r_phase      <= n_phase;
                r_run        <= n_run;
                r_last       <= n_last;
                r_park       <= n_park;
                r_dark_ticks <= n_dark_ticks;
                r_win_ticks  <= n_win_ticks;
                r_started    <= n_started;
            end
            if (in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready) begin
            r_action      <= i_in.action;
            r_now         <= i_in.now_us;
            r_light       <= i_in.light_level;
            r_idx         <= i_in.plant_index;
            r_back_pick   <= i_in.step_back_pick;
            r_wander_pick <= i_in.wander_pick;
        end
        if (advance) begin
            r_coil        <= n_run ? lssc_pkg::coil_lookup(n_phase) : '0;
            r_out_pos     <= n_pos;
            r_out_dir     <= n_dir;
            r_out_run     <= n_run;
            r_out_stepped <= n_stepped;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.coil_pattern = r_coil;
    assign o_out.position     = r_out_pos;
    assign o_out.heading      = r_out_dir;
    assign o_out.running      = r_out_run;
    assign o_out.stepped      = r_out_stepped;

    a_coils_off_when_stopped : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.running |-> o_out.coil_pattern == '0)
        else $error("coils driven while stopped");

    a_coils_half_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.running |->
            ($countones(o_out.coil_pattern) == 1 || $countones(o_out.coil_pattern) == 2))
        else $error("coil pattern is not a half-step pattern");

    a_ready_only_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_in_valid && r_out_valid && !o_out.ready)
        else $error("input stalled without an output stall");

    a_heading_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dir != 2'b10)
        else $error("heading register holds an unused code");

    a_phase_moves_one : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_stepped |=> (r_phase == $past(r_phase) + 3'd1 ||
                                  r_phase == $past(r_phase) - 3'd1))
        else $error("phase moved by more than one half step");

endmodule

// ----- bench/testbench.sv -----
module testbench;

    typedef struct packed {
        logic               action;
        logic [31:0]        now_us;
        logic [15:0]        light_level;
        logic [15:0]        plant_index;
        logic               step_back_pick;
        logic               wander_pick;
    } t_motor_cmd;

    typedef struct packed {
        logic [3:0]         coil_pattern;
        logic signed [17:0] position;
        logic signed [1:0]  heading;
        logic               running;
        logic               stepped;
    } t_motor_drive;

    localparam logic [3:0] HALF_STEP_COILS [8] = '{
        4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
    };
    localparam int QUIET_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;

    lssc_in_if  in_bus ();
    lssc_out_if out_bus ();
    lssc_cfg_if cfg_bus ();

    light_seeking_stepper_controller uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    // motor state as the block should hold it
    int                 m_pos          = 0;
    logic signed [1:0]  m_dir          = lssc_pkg::DIR_FORWARD;
    logic [2:0]         m_phase        = '0;
    bit                 m_run          = 1'b0;
    logic [31:0]        m_last_stamp   = '0;
    int                 m_park         = 1;
    int                 m_dark_ticks   = 0;
    int                 m_window_ticks = 0;
    bit                 m_started      = 1'b0;

    int cfg_travel        = int'(lssc_pkg::RST_TRAVEL_LENGTH);
    int cfg_interval      = int'(lssc_pkg::RST_STEP_INTERVAL_US);
    int cfg_dark          = int'(lssc_pkg::RST_DARK_LEVEL);
    int cfg_bright        = int'(lssc_pkg::RST_BRIGHT_LEVEL);
    int cfg_win_lo        = int'(lssc_pkg::RST_INDEX_WINDOW_LOW);
    int cfg_win_hi        = int'(lssc_pkg::RST_INDEX_WINDOW_HIGH);
    int cfg_dark_persist  = int'(lssc_pkg::RST_DARK_PERSIST);
    int cfg_index_persist = int'(lssc_pkg::RST_INDEX_PERSIST);

    t_motor_drive drive_fifo [$];
    logic [31:0]  stamp_us   = '0;
    int           fail_count = 0;
    bit           src_idle   = 1'b0;
    bit           sink_idle  = 1'b0;
    int           sink_hold  = 0;
    int           sink_wait  = 0;

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // bounce, dark and window checks; returns whether the run goes on
    function automatic bit motor_checks(logic [15:0] light, logic [15:0] idx);
        if (m_pos <= lssc_pkg::END_MARGIN) begin
            m_pos = cfg_travel - lssc_pkg::REBOUND_OFFSET;
            m_dir = lssc_pkg::DIR_FORWARD;
            return 1'b1;
        end
        if (m_pos >= cfg_travel - lssc_pkg::END_MARGIN) begin
            m_pos = lssc_pkg::REBOUND_OFFSET;
            m_dir = lssc_pkg::DIR_BACK;
            return 1'b1;
        end
        if (m_dir != lssc_pkg::DIR_BACK && light < cfg_dark) begin
            if (m_dark_ticks >= cfg_dark_persist) begin
                m_dir = lssc_pkg::DIR_BACK;
                m_pos = lssc_pkg::REBOUND_OFFSET;
                m_window_ticks = 0;
                return 1'b1;
            end
            m_dark_ticks++;
        end
        if (light > cfg_bright)
            m_dark_ticks = 0;
        if (idx > cfg_win_lo && idx < cfg_win_hi) begin
            if (m_window_ticks >= cfg_index_persist) begin
                m_park = cfg_travel - lssc_pkg::REBOUND_OFFSET;
                m_dir = lssc_pkg::DIR_WANDER;
                m_window_ticks = 0;
                return 1'b0;
            end
            m_window_ticks++;
        end else begin
            m_window_ticks = 0;
        end
        return 1'b1;
    endfunction

    function automatic t_motor_drive advance_motor(t_motor_cmd c);
        t_motor_drive      r;
        int                d;
        bit                took;
        logic [31:0]       elapsed;
        logic signed [17:0] pos18;
        took = 1'b0;
        if (c.action) begin
            if (m_started) begin
                if (c.wander_pick)
                    m_dir = lssc_pkg::DIR_WANDER;
                else if (c.plant_index <= lssc_pkg::FORWARD_INDEX_LIMIT)
                    m_dir = lssc_pkg::DIR_FORWARD;
            end else begin
                m_dir = lssc_pkg::DIR_FORWARD;
                m_park = 1;
                m_started = 1'b1;
            end
            m_pos = m_park;
            m_last_stamp = c.now_us;
            m_run = 1'b1;
        end else if (m_run) begin
            elapsed = c.now_us - m_last_stamp;
            if (elapsed >= cfg_interval) begin
                d = m_dir;
                if (d == 0)
                    d = c.step_back_pick ? -1 : 1;
                pos18 = 18'(m_pos + d);
                m_pos = pos18;
                m_phase = m_phase + 3'(d);
                m_last_stamp = c.now_us;
                took = 1'b1;
            end
            m_run = motor_checks(c.light_level, c.plant_index);
        end
        r.coil_pattern = m_run ? HALF_STEP_COILS[m_phase] : 4'h0;
        r.position     = m_pos[17:0];
        r.heading      = m_dir;
        r.running      = m_run;
        r.stepped      = took;
        return r;
    endfunction

    function automatic int pick_gap(bit on);
        int r;
        if (!on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic t_motor_cmd make_cmd(int act, int adv, int light, int idx,
                                            int back, int wander);
        t_motor_cmd c;
        stamp_us = stamp_us + 32'(adv);
        c.action         = 1'(act);
        c.now_us         = stamp_us;
        c.light_level    = 16'(light);
        c.plant_index    = 16'(idx);
        c.step_back_pick = 1'(back);
        c.wander_pick    = 1'(wander);
        return c;
    endfunction

    // mostly well-timed ticks with light and index steered at the thresholds
    function automatic t_motor_cmd random_cmd(int dark_pct, int inside_pct);
        int act;
        int adv;
        int light;
        int idx;
        int r;
        if (m_run)
            act = ($urandom_range(0, 29) == 0) ? 1 : 0;
        else
            act = ($urandom_range(0, 3) != 0) ? 1 : 0;
        case ($urandom_range(0, 9))
            0:       adv = 0;
            1:       adv = cfg_interval - 1;
            7:       adv = $urandom_range(0, 2 * cfg_interval);
            8:       adv = $urandom;
            9:       adv = $urandom_range(cfg_interval / 2, cfg_interval);
            default: adv = cfg_interval + $urandom_range(0, 3);
        endcase
        r = $urandom_range(0, 99);
        if (r < dark_pct && cfg_dark > 0)
            light = $urandom_range(0, cfg_dark - 1);
        else if (r < dark_pct + 15 && cfg_bright < 65535)
            light = $urandom_range(cfg_bright + 1, 65535);
        else
            light = $urandom_range(0, 65535);
        r = $urandom_range(0, 99);
        if (r < inside_pct && cfg_win_hi > cfg_win_lo + 1)
            idx = $urandom_range(cfg_win_lo + 1, cfg_win_hi - 1);
        else if (r < inside_pct + 10)
            idx = $urandom_range(9829, 9832);
        else
            idx = $urandom_range(0, 65535);
        return make_cmd(act, adv, light, idx, $urandom_range(0, 1), $urandom_range(0, 1));
    endfunction

    task automatic send_cmd(t_motor_cmd c);
        int gap;
        @(negedge i_clk);
        in_bus.valid          <= 1'b1;
        in_bus.action         <= c.action;
        in_bus.now_us         <= c.now_us;
        in_bus.light_level    <= c.light_level;
        in_bus.plant_index    <= c.plant_index;
        in_bus.step_back_pick <= c.step_back_pick;
        in_bus.wander_pick    <= c.wander_pick;
        @(posedge i_clk);
        while (!in_bus.ready)
            @(posedge i_clk);
        drive_fifo.push_back(advance_motor(c));
        gap = pick_gap(src_idle);
        if (gap > 0) begin
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_results();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (drive_fifo.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_setting(lssc_pkg::t_cfg_idx idx, int value);
        logic [lssc_pkg::CFG_DATA_W-1:0] data;
        data = lssc_pkg::CFG_DATA_W'(value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
        case (idx)
            lssc_pkg::CFG_TRAVEL_LENGTH:     cfg_travel        = int'(data[15:0]);
            lssc_pkg::CFG_STEP_INTERVAL_US:  cfg_interval      = int'(data);
            lssc_pkg::CFG_DARK_LEVEL:        cfg_dark          = int'(data[15:0]);
            lssc_pkg::CFG_BRIGHT_LEVEL:      cfg_bright        = int'(data[15:0]);
            lssc_pkg::CFG_INDEX_WINDOW_LOW:  cfg_win_lo        = int'(data[15:0]);
            lssc_pkg::CFG_INDEX_WINDOW_HIGH: cfg_win_hi        = int'(data[15:0]);
            lssc_pkg::CFG_DARK_PERSIST:      cfg_dark_persist  = int'(data[7:0]);
            lssc_pkg::CFG_INDEX_PERSIST:     cfg_index_persist = int'(data[7:0]);
            default: ;
        endcase
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic apply_settings(int travel, int interval, int dark, int bright,
                                  int win_lo, int win_hi, int dark_p, int index_p);
        write_setting(lssc_pkg::CFG_TRAVEL_LENGTH, travel);
        write_setting(lssc_pkg::CFG_STEP_INTERVAL_US, interval);
        write_setting(lssc_pkg::CFG_DARK_LEVEL, dark);
        write_setting(lssc_pkg::CFG_BRIGHT_LEVEL, bright);
        write_setting(lssc_pkg::CFG_INDEX_WINDOW_LOW, win_lo);
        write_setting(lssc_pkg::CFG_INDEX_WINDOW_HIGH, win_hi);
        write_setting(lssc_pkg::CFG_DARK_PERSIST, dark_p);
        write_setting(lssc_pkg::CFG_INDEX_PERSIST, index_p);
    endtask

    task automatic test_idle_ticks();
        send_cmd(make_cmd(0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(0, 32'hFFFF_FFFF, 65535, 65535, 1, 1));
    endtask

    // first start ignores the wander coin; the next step crosses the time wrap
    task automatic test_first_start();
        send_cmd(make_cmd(1, 0, 700, 65535, 0, 1));
        send_cmd(make_cmd(0, 1000, 700, 0, 0, 0));
        send_cmd(make_cmd(0, 999, 700, 0, 0, 0));
    endtask

    task automatic test_window_stop();
        send_cmd(make_cmd(0, 1, 700, 8192, 0, 0));
        send_cmd(make_cmd(0, 1000, 700, 8193, 0, 0));
        send_cmd(make_cmd(0, 1000, 700, 16219, 0, 0));
        send_cmd(make_cmd(0, 1000, 700, 12000, 0, 0));
        send_cmd(make_cmd(0, 1000, 700, 12000, 0, 0));
        send_cmd(make_cmd(0, 1000, 700, 12000, 0, 0));
        send_cmd(make_cmd(1, 5, 700, 0, 0, 1));
        send_cmd(make_cmd(0, 1000, 700, 0, 1, 0));
        send_cmd(make_cmd(0, 1000, 700, 0, 0, 0));
        // restart while running: index just above and at the forward limit
        send_cmd(make_cmd(1, 5, 700, 9831, 0, 0));
        send_cmd(make_cmd(1, 5, 700, 9830, 0, 0));
    endtask

    task automatic test_dark_reversal();
        int k;
        send_cmd(make_cmd(0, 1000, 0, 0, 0, 0));
        send_cmd(make_cmd(0, 1000, 1001, 0, 0, 0));
        for (k = 0; k < 6; k++)
            send_cmd(make_cmd(0, 1000, 0, 0, 0, 0));
    endtask

    // park far up a long track, then shrink the track so the restart lands past its end
    task automatic test_upper_bounce();
        int k;
        wait_results();
        write_setting(lssc_pkg::CFG_TRAVEL_LENGTH, 65535);
        send_cmd(make_cmd(1, 5, 700, 0, 0, 0));
        for (k = 0; k < 4; k++)
            send_cmd(make_cmd(0, 1000, 700, 12000, 0, 0));
        wait_results();
        write_setting(lssc_pkg::CFG_TRAVEL_LENGTH, 2200);
        send_cmd(make_cmd(1, 5, 700, 0, 0, 0));
        send_cmd(make_cmd(0, 1000, 700, 0, 0, 0));
    endtask

    task automatic test_backpressure();
        int k;
        wait_results();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        sink_hold = 60;
        send_cmd(make_cmd(1, 7, 700, 0, 0, 0));
        for (k = 0; k < 23; k++)
            send_cmd(random_cmd(30, 40));
        wait_results();
        for (k = 0; k < 10; k++)
            send_cmd(random_cmd(30, 40));
    endtask

    task automatic test_config_sweep();
        int p;
        int k;
        int lo;
        int dk;
        int dark_pct;
        int inside_pct;
        for (p = 0; p < 6; p++) begin
            wait_results();
            src_idle  = (p % 2 == 0);
            sink_idle = (p % 3 != 1);
            case (p)
                0: apply_settings(2200, 1, 65535, 0, 0, 65535, 0, 0);
                1: apply_settings(65535, 4294967, 0, 65535, 65535, 0, 255, 255);
                default: begin
                    lo = $urandom_range(0, 40000);
                    dk = $urandom_range(0, 3000);
                    apply_settings($urandom_range(2200, 65535),
                                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4294967)
                                                               : $urandom_range(1, 3000),
                                   dk, dk + $urandom_range(0, 3000),
                                   lo, lo + $urandom_range(2, 20000),
                                   $urandom_range(0, 12), $urandom_range(0, 12));
                end
            endcase
            dark_pct   = $urandom_range(10, 70);
            inside_pct = $urandom_range(20, 80);
            for (k = 0; k < (p < 2 ? 60 : 70); k++)
                send_cmd(random_cmd(dark_pct, inside_pct));
        end
    endtask

    // result side: random stalls, plus a long hold when one is requested
    initial begin
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                out_bus.ready <= 1'b0;
                sink_hold--;
            end else if (sink_wait > 0) begin
                out_bus.ready <= 1'b0;
                sink_wait--;
            end else begin
                out_bus.ready <= 1'b1;
                sink_wait = pick_gap(sink_idle);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_motor_drive want;
        t_motor_drive got;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got = {out_bus.coil_pattern, out_bus.position, out_bus.heading,
                   out_bus.running, out_bus.stepped};
            if (drive_fifo.size() == 0) begin
                $display("%0t: result with nothing pending: %s",
                         $time, "coil pos dir run step follow");
                $display("%0t:          coil=%h pos=%0d dir=%0d run=%b step=%b",
                         $time, got.coil_pattern, got.position, got.heading,
                         got.running, got.stepped);
                fail_count++;
            end else begin
                want = drive_fifo.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected coil=%h pos=%0d dir=%0d run=%b step=%b",
                             $time, want.coil_pattern, want.position, want.heading,
                             want.running, want.stepped);
                    $display("%0t:          actual   coil=%h pos=%0d dir=%0d run=%b step=%b",
                             $time, got.coil_pattern, got.position, got.heading,
                             got.running, got.stepped);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        i_rst_n               = 1'b0;
        in_bus.valid          = 1'b0;
        in_bus.action         = 1'b0;
        in_bus.now_us         = '0;
        in_bus.light_level    = '0;
        in_bus.plant_index    = '0;
        in_bus.step_back_pick = 1'b0;
        in_bus.wander_pick    = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = lssc_pkg::CFG_TRAVEL_LENGTH;
        cfg_bus.data          = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        sink_idle = 1'b1;
        test_idle_ticks();
        test_first_start();
        test_window_stop();
        test_dark_reversal();
        test_upper_bounce();
        test_backpressure();
        test_config_sweep();
        wait_results();
        repeat (10) @(posedge i_clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
